[sv/cmb_pkg.sv]
package cmb_pkg;

  localparam int unsigned ColorW   = 15;
  localparam int unsigned ChanW    = 5;
  localparam int unsigned NumChan  = 3;
  localparam int unsigned SourceW  = 3;
  localparam int unsigned MaskW    = 7;
  localparam int unsigned BrightW  = 4;
  localparam int unsigned PixelW   = BrightW + ColorW;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 15;

  localparam logic [SourceW-1:0] SrcBackdrop = 3'd6;
  localparam logic [ChanW-1:0]   ChanMax     = 5'd31;

  localparam logic [CfgIdxW-1:0] RegHiresMode     = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMathEnable    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegUseSubLayer   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHalveEnable   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSubtractMode  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegFixedColor    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegBrightness    = 3'd6;

  typedef struct packed {
    logic               hires_mode;
    logic [MaskW-1:0]   math_enable_mask;
    logic               use_sub_layer;
    logic               halve_enable;
    logic               subtract_mode;
    logic [ColorW-1:0]  fixed_color;
    logic [BrightW-1:0] brightness;
  } cfg_t;

  typedef struct packed {
    logic [ColorW-1:0]  color;
    logic [SourceW-1:0] source;
  } layer_px_t;

endpackage

[sv/rgb555_color_math_blend_unit.sv]
// Channel   Direction  Signals                                   Handshake
// command   in         main/sub color, source, window bits       start, busy
// result    out        left_pixel_o, right_pixel_o               result_valid_o
// config    in         cfg_index_i, cfg_wdata_i                  cfg_we_i
//
// One item per cycle; busy stays low, so start is taken at every edge.
// Path: input register, then shading into the result register.
// The result strobe lasts one cycle and cannot be held off.
// Reset clears the config register and the valid flags; payload registers are not reset.
module rgb555_color_math_blend_unit
  import cmb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ColorW-1:0]   main_color_i,
  input  logic [SourceW-1:0]  main_source_i,
  input  logic [ColorW-1:0]   sub_color_i,
  input  logic [SourceW-1:0]  sub_source_i,
  input  logic                main_window_i,
  input  logic                sub_window_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                result_valid_o,
  output logic [PixelW-1:0]   left_pixel_o,
  output logic [PixelW-1:0]   right_pixel_o
);

  cfg_t              cfg_q, cfg_d;
  logic              in_valid_q;
  layer_px_t         main_q;
  layer_px_t         sub_q;
  logic              main_window_q;
  logic              sub_window_q;
  logic              res_valid_q;
  logic [PixelW-1:0] left_q, left_d;
  logic [PixelW-1:0] right_q, right_d;
  logic [ColorW-1:0] right_color;
  logic [ColorW-1:0] swap_color;
  logic              accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegHiresMode:    cfg_d.hires_mode       = cfg_wdata_i[0];
        RegMathEnable:   cfg_d.math_enable_mask = cfg_wdata_i[MaskW-1:0];
        RegUseSubLayer:  cfg_d.use_sub_layer    = cfg_wdata_i[0];
        RegHalveEnable:  cfg_d.halve_enable     = cfg_wdata_i[0];
        RegSubtractMode: cfg_d.subtract_mode    = cfg_wdata_i[0];
        RegFixedColor:   cfg_d.fixed_color      = cfg_wdata_i[ColorW-1:0];
        RegBrightness:   cfg_d.brightness       = cfg_wdata_i[BrightW-1:0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  cmb_shade u_shade_right (
    .cfg_i         (cfg_q),
    .front_i       (main_q),
    .back_i        (sub_q),
    .main_window_i (main_window_q),
    .sub_window_i  (sub_window_q),
    .color_o       (right_color)
  );

  cmb_shade u_shade_swap (
    .cfg_i         (cfg_q),
    .front_i       (sub_q),
    .back_i        (main_q),
    .main_window_i (main_window_q),
    .sub_window_i  (sub_window_q),
    .color_o       (swap_color)
  );

  assign right_d = {cfg_q.brightness, right_color};
  assign left_d  = {cfg_q.brightness, cfg_q.hires_mode ? swap_color : right_color};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= '0;
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      in_valid_q  <= accept;
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      main_q        <= '{color: main_color_i, source: main_source_i};
      sub_q         <= '{color: sub_color_i, source: sub_source_i};
      main_window_q <= main_window_i;
      sub_window_q  <= sub_window_i;
    end
    if (in_valid_q) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign result_valid_o = res_valid_q;
  assign left_pixel_o   = left_q;
  assign right_pixel_o  = right_q;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##2 result_valid_o)
    else $error("item accepted without a result two cycles later");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> $past(accept, 2))
    else $error("result strobe without an accepted item");

  a_normal_mode_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !cfg_q.hires_mode |-> left_pixel_o == right_pixel_o)
    else $error("left and right pixels differ outside hi-res mode");

  a_brightness: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> left_pixel_o[PixelW-1:ColorW] == cfg_q.brightness &&
                       right_pixel_o[PixelW-1:ColorW] == cfg_q.brightness)
    else $error("brightness field does not match the register");
`endif

endmodule

[sv/cmb_shade.sv]
module cmb_shade
  import cmb_pkg::*;
(
  input  cfg_t              cfg_i,
  input  layer_px_t         front_i,
  input  layer_px_t         back_i,
  input  logic              main_window_i,
  input  logic              sub_window_i,
  output logic [ColorW-1:0] color_o
);

  logic [MaskW:0]    enable_vec;
  logic              math_on;
  logic              halve;
  logic [ColorW-1:0] front_color;
  logic [ColorW-1:0] other_color;
  logic [ColorW-1:0] blended;

  assign enable_vec  = {1'b0, cfg_i.math_enable_mask};
  assign math_on     = sub_window_i && enable_vec[front_i.source];
  assign front_color = main_window_i ? front_i.color : '0;
  assign other_color = cfg_i.use_sub_layer ? back_i.color : cfg_i.fixed_color;
  assign halve       = cfg_i.halve_enable && main_window_i &&
                       (!cfg_i.use_sub_layer || (back_i.source != SrcBackdrop));

  always_comb begin
    logic [ChanW-1:0] ca;
    logic [ChanW-1:0] cb;
    logic [ChanW:0]   sum;
    logic [ChanW-1:0] diff;
    blended = '0;
    for (int unsigned c = 0; c < NumChan; c++) begin
      ca   = front_color[c*ChanW +: ChanW];
      cb   = other_color[c*ChanW +: ChanW];
      sum  = {1'b0, ca} + {1'b0, cb};
      diff = (ca > cb) ? ca - cb : '0;
      if (!cfg_i.subtract_mode) begin
        if (halve) begin
          blended[c*ChanW +: ChanW] = sum[ChanW:1];
        end else if (sum[ChanW]) begin
          blended[c*ChanW +: ChanW] = ChanMax;
        end else begin
          blended[c*ChanW +: ChanW] = sum[ChanW-1:0];
        end
      end else begin
        blended[c*ChanW +: ChanW] = halve ? {1'b0, diff[ChanW-1:1]} : diff;
      end
    end
  end

  assign color_o = math_on ? blended : front_color;

endmodule

[tb/sv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cmb_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam logic [SourceW-1:0] SrcTop    = 3'd7;

  typedef struct packed {
    layer_px_t main_px;
    layer_px_t sub_px;
    logic      main_win;
    logic      sub_win;
  } column_t;

  typedef struct packed {
    logic [PixelW-1:0] left_px;
    logic [PixelW-1:0] right_px;
  } pix_pair_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic [ColorW-1:0]   main_color_i   = '0;
  logic [SourceW-1:0]  main_source_i  = '0;
  logic [ColorW-1:0]   sub_color_i    = '0;
  logic [SourceW-1:0]  sub_source_i   = '0;
  logic                main_window_i  = 1'b0;
  logic                sub_window_i   = 1'b0;
  logic                cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_wdata_i    = '0;
  logic                result_valid_o;
  logic [PixelW-1:0]   left_pixel_o;
  logic [PixelW-1:0]   right_pixel_o;

  cfg_t      regs;
  column_t   col_q[$];
  pix_pair_t px_expect_q[$];
  column_t   drv_col;
  int        fed;
  int        mismatches;

  rgb555_color_math_blend_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .main_color_i  (main_color_i),
    .main_source_i (main_source_i),
    .sub_color_i   (sub_color_i),
    .sub_source_i  (sub_source_i),
    .main_window_i (main_window_i),
    .sub_window_i  (sub_window_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .result_valid_o(result_valid_o),
    .left_pixel_o  (left_pixel_o),
    .right_pixel_o (right_pixel_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [ColorW-1:0] mix_channels(input logic [ColorW-1:0] a,
                                                     input logic [ColorW-1:0] b,
                                                     input logic halve);
    logic [ColorW-1:0] res;
    logic [ChanW-1:0]  ca;
    logic [ChanW-1:0]  cb;
    logic [ChanW:0]    v;
    res = '0;
    for (int ch = 0; ch < NumChan; ch++) begin
      ca = a[ch*ChanW +: ChanW];
      cb = b[ch*ChanW +: ChanW];
      if (!regs.subtract_mode) begin
        v = {1'b0, ca} + {1'b0, cb};
        if (halve) v = v >> 1;
        else if (v > {1'b0, ChanMax}) v = {1'b0, ChanMax};
      end else begin
        v = (ca > cb) ? {1'b0, ca - cb} : '0;
        if (halve) v = v >> 1;
      end
      res[ch*ChanW +: ChanW] = v[ChanW-1:0];
    end
    return res;
  endfunction

  function automatic logic [ColorW-1:0] shade_px(input layer_px_t front, input layer_px_t back,
                                                 input logic mwin, input logic swin);
    logic [ColorW-1:0] fc;
    fc = mwin ? front.color : '0;
    if (!swin) return fc;
    if (front.source > SrcBackdrop || !regs.math_enable_mask[front.source]) return fc;
    if (!regs.use_sub_layer) return mix_channels(fc, regs.fixed_color, regs.halve_enable && mwin);
    return mix_channels(fc, back.color,
                        regs.halve_enable && mwin && back.source != SrcBackdrop);
  endfunction

  function automatic pix_pair_t shade_column(input column_t c);
    pix_pair_t p;
    logic [ColorW-1:0] right_c;
    logic [ColorW-1:0] left_c;
    right_c = shade_px(c.main_px, c.sub_px, c.main_win, c.sub_win);
    left_c  = regs.hires_mode ? shade_px(c.sub_px, c.main_px, c.main_win, c.sub_win) : right_c;
    p.left_px  = {regs.brightness, left_c};
    p.right_px = {regs.brightness, right_c};
    return p;
  endfunction

  function automatic logic [ColorW-1:0] rand_color();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return ColorW'($urandom_range(32767));
    endcase
  endfunction

  function automatic column_t rand_column();
    column_t c;
    c.main_px.color  = rand_color();
    c.main_px.source = SourceW'($urandom_range(7));
    c.sub_px.color   = rand_color();
    c.sub_px.source  = ($urandom_range(3) == 0) ? SrcBackdrop : SourceW'($urandom_range(7));
    c.main_win       = $urandom_range(99) < 80;
    c.sub_win        = $urandom_range(99) < 80;
    return c;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.hires_mode    = 1'($urandom_range(1));
    c.use_sub_layer = 1'($urandom_range(1));
    c.halve_enable  = 1'($urandom_range(1));
    c.subtract_mode = 1'($urandom_range(1));
    case ($urandom_range(4))
      0:       c.math_enable_mask = '1;
      1:       c.math_enable_mask = '0;
      default: c.math_enable_mask = MaskW'($urandom_range(127));
    endcase
    case ($urandom_range(3))
      0:       c.fixed_color = '0;
      1:       c.fixed_color = '1;
      default: c.fixed_color = ColorW'($urandom_range(32767));
    endcase
    case ($urandom_range(3))
      0:       c.brightness = '0;
      1:       c.brightness = '1;
      default: c.brightness = BrightW'($urandom_range(15));
    endcase
    return c;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
      fed   <= 0;
    end else if (!start || !busy) begin
      if (col_q.size() != 0 && ((fed >= 400 && fed < 600) || $urandom_range(99) >= 12)) begin
        drv_col = col_q.pop_front();
        start         <= 1'b1;
        main_color_i  <= drv_col.main_px.color;
        main_source_i <= drv_col.main_px.source;
        sub_color_i   <= drv_col.sub_px.color;
        sub_source_i  <= drv_col.sub_px.source;
        main_window_i <= drv_col.main_win;
        sub_window_i  <= drv_col.sub_win;
        fed           <= fed + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    pix_pair_t want;
    column_t   seen;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (px_expect_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: left %05h right %05h", left_pixel_o, right_pixel_o);
          mismatches++;
        end else begin
          want = px_expect_q.pop_front();
          if (left_pixel_o !== want.left_px) begin
            if (mismatches < 10)
              $display("left_pixel mismatch: expected %05h, got %05h",
                       want.left_px, left_pixel_o);
            mismatches++;
          end
          if (right_pixel_o !== want.right_px) begin
            if (mismatches < 10)
              $display("right_pixel mismatch: expected %05h, got %05h",
                       want.right_px, right_pixel_o);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        seen.main_px.color  = main_color_i;
        seen.main_px.source = main_source_i;
        seen.sub_px.color   = sub_color_i;
        seen.sub_px.source  = sub_source_i;
        seen.main_win       = main_window_i;
        seen.sub_win        = sub_window_i;
        px_expect_q.push_back(shade_column(seen));
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegHiresMode:    regs.hires_mode       = val[0];
      RegMathEnable:   regs.math_enable_mask = val[MaskW-1:0];
      RegUseSubLayer:  regs.use_sub_layer    = val[0];
      RegHalveEnable:  regs.halve_enable     = val[0];
      RegSubtractMode: regs.subtract_mode    = val[0];
      RegFixedColor:   regs.fixed_color      = val[ColorW-1:0];
      RegBrightness:   regs.brightness       = val[BrightW-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (col_q.size() != 0 || start || px_expect_q.size() != 0) @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input cfg_t c);
    drain();
    write_reg(RegUnused, CfgDataW'($urandom_range(32767)));
    write_reg(RegHiresMode, CfgDataW'(c.hires_mode));
    write_reg(RegMathEnable, CfgDataW'(c.math_enable_mask));
    write_reg(RegUseSubLayer, CfgDataW'(c.use_sub_layer));
    write_reg(RegHalveEnable, CfgDataW'(c.halve_enable));
    write_reg(RegSubtractMode, CfgDataW'(c.subtract_mode));
    write_reg(RegFixedColor, CfgDataW'(c.fixed_color));
    write_reg(RegBrightness, CfgDataW'(c.brightness));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic push_col(input logic [ColorW-1:0] mc, input logic [SourceW-1:0] ms,
                          input logic [ColorW-1:0] sc, input logic [SourceW-1:0] ss,
                          input logic mw, input logic sw);
    column_t c;
    c.main_px.color  = mc;
    c.main_px.source = ms;
    c.sub_px.color   = sc;
    c.sub_px.source  = ss;
    c.main_win       = mw;
    c.sub_win        = sw;
    col_q.push_back(c);
  endtask

  initial begin
    regs       = '0;
    mismatches = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_col(15'h7fff, 3'd0, 15'h7fff, 3'd0, 1'b1, 1'b1);
    push_col(15'h7fff, SrcTop, 15'h0000, SrcBackdrop, 1'b0, 1'b1);
    push_col(15'h1234, SrcBackdrop, 15'h4321, 3'd2, 1'b1, 1'b0);

    program_regs('{hires_mode: 1'b1, math_enable_mask: 7'h7f, use_sub_layer: 1'b1,
                   halve_enable: 1'b1, subtract_mode: 1'b0, fixed_color: 15'h7fff,
                   brightness: 4'hf});
    push_col(15'h7fff, 3'd0, 15'h7fff, 3'd0, 1'b1, 1'b1);
    push_col(15'h7fff, 3'd1, 15'h7fff, SrcBackdrop, 1'b1, 1'b1);
    push_col(15'h0000, 3'd2, 15'h0000, 3'd3, 1'b1, 1'b1);
    push_col(15'h0421, 3'd3, 15'h7bde, 3'd4, 1'b1, 1'b1);
    push_col(15'h7bde, 3'd5, 15'h0421, SrcBackdrop, 1'b1, 1'b1);
    push_col(15'h001f, SrcBackdrop, 15'h03e0, SrcTop, 1'b1, 1'b1);
    push_col(15'h7c00, SrcTop, 15'h001f, 3'd0, 1'b1, 1'b1);
    push_col(15'h7fff, 3'd4, 15'h7fff, 3'd5, 1'b0, 1'b1);
    push_col(15'h7fff, 3'd4, 15'h7fff, 3'd5, 1'b1, 1'b0);
    push_col(15'h7fff, 3'd4, 15'h7fff, 3'd5, 1'b0, 1'b0);

    program_regs('{hires_mode: 1'b0, math_enable_mask: 7'h55, use_sub_layer: 1'b0,
                   halve_enable: 1'b1, subtract_mode: 1'b1, fixed_color: 15'h0421,
                   brightness: 4'h5});
    push_col(15'h7fff, 3'd0, 15'h1234, 3'd1, 1'b1, 1'b1);
    push_col(15'h0421, 3'd2, 15'h7fff, SrcBackdrop, 1'b1, 1'b1);
    push_col(15'h0000, 3'd4, 15'h7fff, 3'd5, 1'b1, 1'b1);
    push_col(15'h7fff, 3'd1, 15'h0000, 3'd0, 1'b1, 1'b1);
    push_col(15'h7fff, SrcBackdrop, 15'h0000, SrcBackdrop, 1'b0, 1'b1);

    program_regs('{hires_mode: 1'b1, math_enable_mask: 7'h7f, use_sub_layer: 1'b1,
                   halve_enable: 1'b0, subtract_mode: 1'b1, fixed_color: 15'h0000,
                   brightness: 4'ha});
    push_col(15'h7fff, 3'd0, 15'h0421, 3'd1, 1'b1, 1'b1);
    push_col(15'h7bde, SrcBackdrop, 15'h7fff, SrcTop, 1'b1, 1'b1);
    push_col(15'h2a55, 3'd5, 15'h55aa, SrcBackdrop, 1'b1, 1'b1);
    push_col(15'h5555, SrcTop, 15'h2aaa, 3'd3, 1'b1, 1'b1);

    for (int ph = 0; ph < 10; ph++) begin
      program_regs(rand_cfg());
      repeat (100) col_q.push_back(rand_column());
    end

    drain();
    if (mismatches == 0 && px_expect_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
